// File: sv/assert_macros.svh
// Shared assertion macros for the rate evaluator checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("checker assertion failed");

// Check prop on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("checker assertion failed");

`endif

// File: sv/fcr_pkg.sv
`default_nettype none
package fcr_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type Q_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type Q_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_RATIO   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONV_GAIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_SAT_PRY = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_SAT_PRD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_MORT     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_ON_PREY  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRED_TSCALE  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIM_TOL     = 3'd7;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NEG  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   typedef struct packed {
      word_type prey_density;
      word_type pred_density;
      word_type top_density;
   } req_item_type;

   typedef struct packed {
      word_type   prey_rate;
      word_type   pred_rate;
      word_type   top_rate;
      status_type status;
   } rsp_item_type;

   function automatic word_type sat_add(word_type a, word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? Q_MIN : Q_MAX;
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? Q_MIN : Q_MAX;
      end
      return s[WORD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: sv/fcr_delay.sv
`default_nettype none
module fcr_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] dl_ff [DEPTH];

   always_ff @(posedge clock) begin
      dl_ff[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
         dl_ff[i] <= dl_ff[i-1];
      end
   end

   assign q = dl_ff[DEPTH-1];
endmodule
`default_nettype wire

// File: sv/fcr_mul.sv
`default_nettype none
module fcr_mul #(
   parameter int FRAC_BITS = fcr_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  fcr_pkg::word_type a,
   input  fcr_pkg::word_type b,
   output fcr_pkg::word_type p
);
   import fcr_pkg::*;

   localparam int PW = 2 * WORD_BITS + 1;

   logic [WORD_BITS-1:0]   ma_ff, mb_ff;
   logic                   neg1_ff, neg2_ff;
   logic [2*WORD_BITS-1:0] prod_ff;
   logic [PW-1:0]          rnd;
   logic                   over;
   word_type               p_ff;

   // round to nearest, ties away from zero, on the magnitude
   always_comb begin
      rnd  = ({1'b0, prod_ff} + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      over = neg2_ff ? (|rnd[PW-1:WORD_BITS] || (rnd[WORD_BITS-1] && |rnd[WORD_BITS-2:0]))
                     : |rnd[PW-1:WORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      ma_ff   <= a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
      mb_ff   <= b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
      neg1_ff <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      prod_ff <= {{WORD_BITS{1'b0}}, ma_ff} * {{WORD_BITS{1'b0}}, mb_ff};
      neg2_ff <= neg1_ff;
      if (over) begin
         p_ff <= neg2_ff ? Q_MIN : Q_MAX;
      end else begin
         p_ff <= neg2_ff ? -word_type'(rnd[WORD_BITS-1:0]) : word_type'(rnd[WORD_BITS-1:0]);
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

// File: sv/fcr_div.sv
`default_nettype none
module fcr_div #(
   parameter int FRAC_BITS = fcr_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  fcr_pkg::word_type n,
   input  fcr_pkg::word_type d,
   output fcr_pkg::word_type q
);
   import fcr_pkg::*;

   localparam int ND = WORD_BITS + FRAC_BITS;
   localparam int QW = ND + 1;

   typedef struct packed {
      logic neg;
      logic dz;
      logic npos;
      logic nneg;
   } div_flag_type;

   logic [WORD_BITS-1:0] rem_ff [ND+1];
   logic [ND-1:0]        qd_ff  [ND+1];
   logic [WORD_BITS-1:0] ud_ff  [ND+1];
   div_flag_type         fl_ff  [ND+1];

   logic                 rnd;
   logic [QW-1:0]        qr_ff;
   div_flag_type         flr_ff;
   logic                 over;
   word_type             q_ff;

   // take magnitudes, load the scaled dividend
   always_ff @(posedge clock) begin
      rem_ff[0]     <= '0;
      qd_ff[0]      <= {(n[WORD_BITS-1] ? WORD_BITS'(-n) : WORD_BITS'(n)), {FRAC_BITS{1'b0}}};
      ud_ff[0]      <= d[WORD_BITS-1] ? WORD_BITS'(-d) : WORD_BITS'(d);
      fl_ff[0].neg  <= n[WORD_BITS-1] ^ d[WORD_BITS-1];
      fl_ff[0].dz   <= (d == '0);
      fl_ff[0].npos <= !n[WORD_BITS-1] && (n != '0);
      fl_ff[0].nneg <= n[WORD_BITS-1];
   end

   // one quotient bit per stage
   for (genvar k = 0; k < ND; k++) begin : g_step
      logic [WORD_BITS:0] rsh;
      logic               ge;
      assign rsh = {rem_ff[k], qd_ff[k][ND-1]};
      assign ge  = rsh >= {1'b0, ud_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? WORD_BITS'(rsh - {1'b0, ud_ff[k]}) : WORD_BITS'(rsh);
         qd_ff[k+1]  <= {qd_ff[k][ND-2:0], ge};
         ud_ff[k+1]  <= ud_ff[k];
         fl_ff[k+1]  <= fl_ff[k];
      end
   end

   assign rnd = {rem_ff[ND], 1'b0} >= {1'b0, ud_ff[ND]};

   always_comb begin
      over = flr_ff.neg
             ? (|qr_ff[QW-1:WORD_BITS] || (qr_ff[WORD_BITS-1] && |qr_ff[WORD_BITS-2:0]))
             : |qr_ff[QW-1:WORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      qr_ff  <= {1'b0, qd_ff[ND]} + QW'(rnd);
      flr_ff <= fl_ff[ND];
      if (flr_ff.dz) begin
         q_ff <= flr_ff.npos ? Q_MAX : (flr_ff.nneg ? Q_MIN : '0);
      end else if (over) begin
         q_ff <= flr_ff.neg ? Q_MIN : Q_MAX;
      end else begin
         q_ff <= flr_ff.neg ? -word_type'(qr_ff[WORD_BITS-1:0])
                            : word_type'(qr_ff[WORD_BITS-1:0]);
      end
   end

   assign q = q_ff;
endmodule
`default_nettype wire

// File: sv/food_chain_rate_evaluator.sv
`default_nettype none
// Food chain rate evaluator: one three-species state in, three derivatives out.
// Input channel: present req_item with start; a transaction is taken at each
// edge with start high and busy low. busy stays low, so a new state can
// enter every cycle.
// Result channel: rsp_item is valid for exactly one cycle while rsp_strobe is
// high. The receiver cannot stall; results leave in input order.
// Default format Q8.24. Throughput is one transaction per cycle; the latency
// is set by the long divider pipelines, which retire one quotient bit per stage.
// Configuration: csr_index/csr_data are written when csr_valid is high;
// csr_ready is always high. Write registers only while no transaction is in
// flight.
// Reset (synchronous, active high) clears all in-flight transactions and
// restores the default coefficients; no clearing pass is needed.
module food_chain_rate_evaluator #(
   parameter int FRAC_BITS = fcr_pkg::FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  fcr_pkg::req_item_type                 req_item,
   output logic                                  rsp_strobe,
   output fcr_pkg::rsp_item_type                 rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fcr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fcr_pkg::WORD_BITS-1:0]         csr_data
);
   import fcr_pkg::*;

   localparam int LD  = WORD_BITS + FRAC_BITS + 3;   // divider latency
   localparam int LAT = LD + 10;                     // accept to strobe
   localparam int CW  = ((WORD_BITS > FRAC_BITS + 1) ? WORD_BITS : FRAC_BITS + 1) + 1;
   localparam int TW  = FRAC_BITS + 1;

   // reset image of 1.0 is truncated; the working constant saturates
   localparam word_type ONE_RST = word_type'(64'd1 << FRAC_BITS);
   localparam word_type ONE_Q   = (FRAC_BITS >= WORD_BITS - 1) ? Q_MAX : ONE_RST;
   localparam logic [TW-1:0] TOL_RST =
      TW'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

   // configuration registers
   word_type         r_ff, e_ff, b_ff, d_ff, g_ff, h_ff, q_ff;
   logic [TW-1:0]    tol_ff;

   logic [LAT-1:0]   vld_ff;
   logic             accept;

   // stage 1: raw state
   word_type         x_raw_ff [3];
   // stage 2: trimmed state
   word_type         xt_ff [3];
   logic             fail_ff;
   logic             fail_in;
   word_type         xt_in [3];
   // stage 3: denominators, status
   word_type         db_ff, dd_ff, om_x0_ff;
   status_type       status_ff;
   word_type         db_in, dd_in;

   // mul and div results
   word_type         p_hx, p_ex, p_xx, p_qx, p_gx;
   word_type         x1_d5, x2_d5, db_d5, dd_d5;
   word_type         div1, div2, div3, div4;
   word_type         p_hx_e, p_gx_e, om_x0_e;
   word_type         x0_f, p_qx_f;
   word_type         t_prey_ff, t_pred_ff, t_top_ff;
   word_type         prey_m, pred_m, top_m;
   logic [1:0]       status_m;

   rsp_item_type     rsp_ff;

   assign accept    = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // hold the coefficients; write one per handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff   <= ONE_RST;
         e_ff   <= ONE_RST;
         b_ff   <= ONE_RST;
         d_ff   <= ONE_RST;
         g_ff   <= '0;
         h_ff   <= '0;
         q_ff   <= ONE_RST;
         tol_ff <= TOL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATE_RATIO:   r_ff   <= word_type'(csr_data);
            CSR_CONV_GAIN:    e_ff   <= word_type'(csr_data);
            CSR_HALF_SAT_PRY: b_ff   <= word_type'(csr_data);
            CSR_HALF_SAT_PRD: d_ff   <= word_type'(csr_data);
            CSR_TOP_MORT:     g_ff   <= word_type'(csr_data);
            CSR_TOP_ON_PREY:  h_ff   <= word_type'(csr_data);
            CSR_PRED_TSCALE:  q_ff   <= word_type'(csr_data);
            CSR_TRIM_TOL:     tol_ff <= TW'(csr_data);
            default: ;
         endcase
      end
   end

   // valid bits march alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // trim small negatives to zero; flag anything at or below -tolerance
   always_comb begin
      logic signed [CW-1:0] xe;
      logic signed [CW-1:0] te;
      logic signed [CW-1:0] s;
      fail_in = 1'b0;
      te      = signed'({{(CW-TW){1'b0}}, tol_ff});
      for (int i = 0; i < 3; i++) begin
         xe       = signed'({{(CW-WORD_BITS){x_raw_ff[i][WORD_BITS-1]}}, x_raw_ff[i]});
         s        = xe + te;
         xt_in[i] = x_raw_ff[i];
         if (x_raw_ff[i][WORD_BITS-1]) begin
            if (s > 0) begin
               xt_in[i] = '0;
            end else begin
               fail_in = 1'b1;
            end
         end
      end
   end

   assign db_in = sat_add(b_ff, xt_ff[0]);
   assign dd_in = sat_add(d_ff, xt_ff[1]);

   always_ff @(posedge clock) begin
      x_raw_ff[0] <= req_item.prey_density;
      x_raw_ff[1] <= req_item.pred_density;
      x_raw_ff[2] <= req_item.top_density;
      xt_ff       <= xt_in;
      fail_ff     <= fail_in;
      db_ff       <= db_in;
      dd_ff       <= dd_in;
      om_x0_ff    <= sat_sub(ONE_Q, xt_ff[0]);
      if (fail_ff) begin
         status_ff <= ST_NEG;
      end else if (db_in == '0 || dd_in == '0) begin
         status_ff <= ST_DIVZ;
      end else begin
         status_ff <= ST_OK;
      end
   end

   // products on the trimmed state: stage 2 in, stage 5 out
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hx (.clock, .a(h_ff),     .b(xt_ff[2]), .p(p_hx));
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ex (.clock, .a(e_ff),     .b(xt_ff[0]), .p(p_ex));
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx (.clock, .a(xt_ff[0]), .b(xt_ff[1]), .p(p_xx));
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_qx (.clock, .a(q_ff),     .b(xt_ff[1]), .p(p_qx));
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_gx (.clock, .a(g_ff),     .b(xt_ff[2]), .p(p_gx));

   // align divider operands to stage 5
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(3)) u_dly_x1 (.clock, .d(xt_ff[1]), .q(x1_d5));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(3)) u_dly_x2 (.clock, .d(xt_ff[2]), .q(x2_d5));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(2)) u_dly_db (.clock, .d(db_ff),    .q(db_d5));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(2)) u_dly_dd (.clock, .d(dd_ff),    .q(dd_d5));

   // quotients: stage 5 in, stage 5 + LD out
   fcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_1 (.clock, .n(x1_d5), .d(db_d5), .q(div1));
   fcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_2 (.clock, .n(p_ex),  .d(db_d5), .q(div2));
   fcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_3 (.clock, .n(x2_d5), .d(dd_d5), .q(div3));
   fcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_4 (.clock, .n(p_xx),  .d(db_d5), .q(div4));

   // carry the other terms past the dividers
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(LD))     u_dly_hx (.clock, .d(p_hx),     .q(p_hx_e));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(LD))     u_dly_gx (.clock, .d(p_gx),     .q(p_gx_e));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(LD + 2)) u_dly_om (.clock, .d(om_x0_ff), .q(om_x0_e));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(LD + 4)) u_dly_x0 (.clock, .d(xt_ff[0]), .q(x0_f));
   fcr_delay #(.WIDTH(WORD_BITS), .DEPTH(LD + 1)) u_dly_qx (.clock, .d(p_qx),     .q(p_qx_f));
   fcr_delay #(.WIDTH(2),         .DEPTH(LD + 6)) u_dly_st (.clock, .d(status_ff), .q(status_m));

   // bracketed terms of the three equations
   always_ff @(posedge clock) begin
      t_prey_ff <= sat_sub(sat_sub(om_x0_e, div1), p_hx_e);
      t_pred_ff <= sat_sub(sat_sub(div2, ONE_Q), div3);
      t_top_ff  <= sat_sub(div4, p_gx_e);
   end

   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_prey (.clock, .a(x0_f),   .b(t_prey_ff), .p(prey_m));
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_pred (.clock, .a(p_qx_f), .b(t_pred_ff), .p(pred_m));
   fcr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_top  (.clock, .a(r_ff),   .b(t_top_ff),  .p(top_m));

   // drop the rates of a failed state
   always_ff @(posedge clock) begin
      rsp_ff.status <= status_type'(status_m);
      if (status_type'(status_m) == ST_NEG) begin
         rsp_ff.prey_rate <= '0;
         rsp_ff.pred_rate <= '0;
         rsp_ff.top_rate  <= '0;
      end else begin
         rsp_ff.prey_rate <= prey_m;
         rsp_ff.pred_rate <= pred_m;
         rsp_ff.top_rate  <= top_m;
      end
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = vld_ff[LAT-1];
endmodule
`default_nettype wire

// File: sv/fcr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fcr_checker #(
   parameter int FRAC_BITS = fcr_pkg::FRAC_BITS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input fcr_pkg::rsp_item_type rsp_item
);
   import fcr_pkg::*;

   localparam int LAT = WORD_BITS + FRAC_BITS + 13;

   `ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_strobe)
   `ASSERT_AT(a_fixed_latency, clock, reset, (start && !busy) |-> ##LAT rsp_strobe)
   `ASSERT_AT(a_no_phantom, clock, reset, rsp_strobe |-> $past(start && !busy, LAT))
   `ASSERT_AT(a_fail_zero, clock, reset, (rsp_strobe && rsp_item.status == ST_NEG) |-> (rsp_item.prey_rate == '0 && rsp_item.pred_rate == '0 && rsp_item.top_rate == '0))
endmodule

bind food_chain_rate_evaluator fcr_checker #(.FRAC_BITS(FRAC_BITS)) u_fcr_checker (.*);
`default_nettype wire
